@@ sv/walsh_hadamard_despreader_macros.svh @@
// Assertion macros for the Walsh-Hadamard despreader.
`ifndef WALSH_HADAMARD_DESPREADER_MACROS_SVH
`define WALSH_HADAMARD_DESPREADER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WHD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define WHD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/whd_pkg.sv @@
// Shared constants and types for the Walsh-Hadamard despreader.
`timescale 1ns / 1ps

package whd_pkg;

	localparam int MAX_USERS      = 16;
	localparam int USER_W         = 4;
	localparam int CHIP_W         = 6;
	localparam int ACC_W          = 10;
	localparam int NU_W           = 5;
	localparam int ML_W           = 13;
	localparam int SC_W           = 12;
	localparam int CFG_IDX_W      = 1;
	localparam int SHORT_CODE_LEN = 8;
	localparam int LONG_CODE_LEN  = 16;
	localparam int MAX_MSG_LEN    = 4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_USERS      = 1'b0,
		REG_MESSAGE_LENGTH = 1'b1
	} cfg_reg_t;

	// Per-cycle control broadcast to every cell.
	typedef struct packed {
		logic acc_en;   // chip accepted this cycle
		logic sym_end;  // accepted chip closes the symbol
		logic shift;    // result chain advances one user
	} cell_ctl_t;

endpackage

@@ sv/whd_cell.sv @@
// One correlator cell: accumulator for one user plus one slot of the result chain.
`timescale 1ns / 1ps

module whd_cell import whd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctl_t                ctl,
	input  logic signed [CHIP_W-1:0] chip,
	input  logic [USER_W-1:0]        pos,
	input  logic [USER_W-1:0]        user,
	input  logic                     slot_in,
	output logic                     slot_q
);

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] chip_x;
	logic signed [ACC_W-1:0] sum;
	logic                    neg;

	assign neg    = ^(user & pos);
	assign chip_x = ACC_W'(chip);
	assign sum    = neg ? (acc_q - chip_x) : (acc_q + chip_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= ctl.sym_end ? '0 : sum;
		end
	end

	// Decision loads the slot at symbol end; otherwise slots shift toward cell 0.
	always_ff @(posedge clk) begin
		if (ctl.acc_en && ctl.sym_end) begin
			slot_q <= ~sum[ACC_W-1] & (|sum);
		end else if (ctl.shift) begin
			slot_q <= slot_in;
		end
	end

endmodule

@@ sv/whd_out.sv @@
// Result drain control: walks user index across one symbol's decided bits.
`timescale 1ns / 1ps

module whd_out import whd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [USER_W-1:0] users_m1,
	input  logic              msg_end_in,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [USER_W-1:0] user_index,
	output logic              last_of_symbol,
	output logic              message_end,
	output logic              drain_free,
	output logic              shift
);

	logic              valid_q;
	logic [USER_W-1:0] idx_q;
	logic [USER_W-1:0] last_idx_q;
	logic              msg_end_q;
	logic              at_last;

	assign at_last        = (idx_q == last_idx_q);
	assign shift          = valid_q & out_ready;
	assign drain_free     = ~valid_q | (out_ready & at_last);
	assign out_valid      = valid_q;
	assign user_index     = idx_q;
	assign last_of_symbol = at_last;
	assign message_end    = msg_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (shift) begin
			if (at_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_idx_q <= users_m1;
			msg_end_q  <= msg_end_in;
		end
	end

endmodule

@@ sv/walsh_hadamard_despreader.sv @@
// Top level of the multi-user Walsh-Hadamard CDMA despreader.
`timescale 1ns / 1ps
`include "walsh_hadamard_despreader_macros.svh"

// Usage:
//  - in channel (in_valid/in_ready, chip_value): one received chip per
//    transaction, sustained at one chip per clock unless in_ready drops.
//  - out channel (out_valid/out_ready): one decided bit per active user per
//    symbol, users in ascending order, one per clock with out_ready high.
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): register writes,
//    always ready; write only while the block is idle.
//  - A row of MAX_USERS identical cells holds the accumulators; every cell
//    updates on each chip. At symbol end the cells latch their decisions
//    and the decisions shift down the row toward cell 0, one per result.
//  - Latency: first result of a symbol is valid the cycle after its last
//    chip is accepted; the rest follow one per cycle with out_ready high.
//  - Throughput: one chip per cycle. in_ready drops only on a chip that
//    closes a symbol while the previous symbol's results are still in the
//    row.
//  - Reset clears accumulators, chip position, symbol counter and the
//    output valid; registers return to 8 users and 16-symbol messages.
//  - A stalled receiver holds the current result; chips keep being taken
//    until the next symbol end needs the row.

module walsh_hadamard_despreader import whd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [CHIP_W-1:0] chip_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [USER_W-1:0]        user_index,
	output logic                     bit_value,
	output logic                     last_of_symbol,
	output logic                     message_end,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [ML_W-1:0]          cfg_data
);

	// Configuration registers
	logic [NU_W-1:0]   num_users_q;
	logic [ML_W-1:0]   msg_len_q;

	// Symbol-level state
	logic [USER_W-1:0] chip_pos_q;
	logic [SC_W-1:0]   sym_cnt_q;

	logic [NU_W-1:0]   users_act;
	logic [USER_W-1:0] users_m1;
	logic              long_code;
	logic [USER_W-1:0] pos_last;
	logic              is_end;
	logic [ML_W-1:0]   msg_len_act;
	logic [ML_W-1:0]   sym_inc;
	logic              msg_end;
	logic              in_fire;
	logic              drain_free;
	logic              shift;
	cell_ctl_t         ctl;
	logic              slot [MAX_USERS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_users_q <= NU_W'(SHORT_CODE_LEN);
			msg_len_q   <= ML_W'(16);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_NUM_USERS:      num_users_q <= cfg_data[NU_W-1:0];
				REG_MESSAGE_LENGTH: msg_len_q   <= cfg_data;
				default:            ;
			endcase
		end
	end

	// Clamp the user count to 1..MAX_USERS; more than 8 users needs the long code.
	always_comb begin
		priority if (num_users_q == '0) begin
			users_act = NU_W'(1);
		end else if (num_users_q > NU_W'(MAX_USERS)) begin
			users_act = NU_W'(MAX_USERS);
		end else begin
			users_act = num_users_q;
		end
	end

	assign users_m1  = USER_W'(users_act - NU_W'(1));
	assign long_code = users_act > NU_W'(SHORT_CODE_LEN);
	assign pos_last  = long_code ? USER_W'(LONG_CODE_LEN - 1) : USER_W'(SHORT_CODE_LEN - 1);
	assign is_end    = chip_pos_q >= pos_last;

	// Clamp the message length to 1..4096.
	always_comb begin
		priority if (msg_len_q == '0) begin
			msg_len_act = ML_W'(1);
		end else if (msg_len_q > ML_W'(MAX_MSG_LEN)) begin
			msg_len_act = ML_W'(MAX_MSG_LEN);
		end else begin
			msg_len_act = msg_len_q;
		end
	end

	assign sym_inc = {1'b0, sym_cnt_q} + ML_W'(1);
	assign msg_end = sym_inc >= msg_len_act;

	// A symbol-closing chip needs the result row empty, or emptying this cycle.
	assign in_ready = ~is_end | drain_free;
	assign in_fire  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_pos_q <= '0;
			sym_cnt_q  <= '0;
		end else if (in_fire) begin
			if (is_end) begin
				chip_pos_q <= '0;
				sym_cnt_q  <= msg_end ? '0 : sym_inc[SC_W-1:0];
			end else begin
				chip_pos_q <= chip_pos_q + 1'b1;
			end
		end
	end

	assign ctl.acc_en  = in_fire;
	assign ctl.sym_end = is_end;
	assign ctl.shift   = shift;

	// Row of correlator cells; results move from cell u+1 to cell u on each shift.
	for (genvar u = 0; u < MAX_USERS; u++) begin : g_cell
		logic nxt;
		if (u == MAX_USERS - 1) begin : g_tail
			assign nxt = 1'b0;
		end else begin : g_mid
			assign nxt = slot[u+1];
		end
		whd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.chip    (chip_value),
			.pos     (chip_pos_q),
			.user    (USER_W'(u)),
			.slot_in (nxt),
			.slot_q  (slot[u])
		);
	end

	whd_out u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (in_fire & is_end),
		.users_m1       (users_m1),
		.msg_end_in     (msg_end),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.user_index     (user_index),
		.last_of_symbol (last_of_symbol),
		.message_end    (message_end),
		.drain_free     (drain_free),
		.shift          (shift)
	);

	assign bit_value = slot[0];

	// Checks
	`WHD_ASSERT_NEXT(a_sym_end_loads, in_fire && is_end,
		out_valid && (user_index == '0), "symbol end did not start a result drain")
	`WHD_ASSERT_NEXT(a_drain_done, out_valid && out_ready && last_of_symbol && !(in_fire && is_end),
		!out_valid, "result drain did not stop after the last user")
	`WHD_ASSERT_NEXT(a_pos_step, in_fire && !is_end,
		chip_pos_q == $past(chip_pos_q) + 1'b1, "chip position did not advance")
	`WHD_ASSERT_NOW(a_no_overrun, in_valid && is_end && out_valid && !out_ready,
		!in_ready, "symbol end taken while results still pending")

endmodule

@@ verif/tb_walsh_hadamard_despreader.sv @@
// Self-checking testbench for the Walsh-Hadamard CDMA despreader.
`timescale 1ns / 1ps

module tb_walsh_hadamard_despreader;
	import whd_pkg::*;

	// One decided bit as it leaves the block.
	typedef struct packed {
		logic [USER_W-1:0] usr;
		logic              decided;
		logic              last;
		logic              msg_end;
	} decision_t;

	// Register settings per random phase. Out-of-range values check saturation.
	localparam int NUM_PHASES = 9;
	localparam int PH_USERS[NUM_PHASES]   = '{31, 0, 16, 9, 8, 1, 17, 4, 12};
	localparam int PH_MSG_LEN[NUM_PHASES] = '{8191, 0, 4096, 3, 1, 4097, 2, 5, 1};
	localparam int CHIPS_PER_PHASE = 26;
	localparam int SETTLE_CYCLES   = 20;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [CHIP_W-1:0] chip_value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [USER_W-1:0]        user_index;
	logic                     bit_value;
	logic                     last_of_symbol;
	logic                     message_end;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	cfg_reg_t                 cfg_index = REG_NUM_USERS;
	logic [ML_W-1:0]          cfg_data = '0;

	// Chips waiting for the driver, and decisions waiting for the block.
	logic signed [CHIP_W-1:0] pending_chips[$];
	decision_t                expected_bits[$];
	int                       mismatch_count = 0;

	// Idle rates in percent, changed only between phases.
	int send_idle_pct = 25;
	int recv_stall_pct = 83;

	// Shadow of the block: registers, chip position, correlators, symbol count.
	logic [NU_W-1:0]          users_reg = 5'd8;
	logic [ML_W-1:0]          msg_len_reg = 13'd16;
	logic [3:0]               chip_pos = '0;
	logic signed [ACC_W-1:0]  corr[MAX_USERS];
	logic [SC_W-1:0]          sym_cnt = '0;

	walsh_hadamard_despreader dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.chip_value     (chip_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.user_index     (user_index),
		.bit_value      (bit_value),
		.last_of_symbol (last_of_symbol),
		.message_end    (message_end),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// User count as the block sees it: zero acts as one, above 16 clips to 16.
	function automatic int eff_users(int n);
		if (n < 1)
			return 1;
		if (n > MAX_USERS)
			return MAX_USERS;
		return n;
	endfunction

	// Correlate one accepted chip; at symbol end queue one decision per user.
	task automatic despread_chip(logic signed [CHIP_W-1:0] c);
		int        users;
		int        code_len;
		int        msg_len;
		logic      done;
		logic [3:0] u4;
		decision_t d;

		users = eff_users(int'(users_reg));
		code_len = (users > SHORT_CODE_LEN) ? LONG_CODE_LEN : SHORT_CODE_LEN;

		// Every correlator moves on every chip, active or not.
		for (int u = 0; u < MAX_USERS; u++) begin
			u4 = u[3:0];
			if (^(u4 & chip_pos))
				corr[u] = corr[u] - ACC_W'(c);
			else
				corr[u] = corr[u] + ACC_W'(c);
		end

		// Mid-symbol: nothing out. A code length that shrank under us ends the
		// symbol as soon as the position is at or past the new last chip.
		if (int'(chip_pos) < code_len - 1) begin
			chip_pos = chip_pos + 4'd1;
			return;
		end

		msg_len = int'(msg_len_reg);
		if (msg_len < 1)
			msg_len = 1;
		if (msg_len > MAX_MSG_LEN)
			msg_len = MAX_MSG_LEN;
		// Reaching or passing the length ends the message (covers a shrink).
		done = (int'(sym_cnt) + 1 >= msg_len);

		for (int u = 0; u < users; u++) begin
			d.usr = USER_W'(u);
			d.decided = (corr[u] > 0);
			d.last = (u == users - 1);
			d.msg_end = done;
			expected_bits.push_back(d);
		end

		for (int u = 0; u < MAX_USERS; u++)
			corr[u] = '0;
		chip_pos = '0;
		sym_cnt = done ? '0 : sym_cnt + 1'b1;
	endtask

	task automatic flag_mismatch(decision_t want, decision_t got, logic have_want);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			if (!have_want)
				$display("%0t: unexpected result user %0d bit %0b last %0b end %0b",
					$realtime, got.usr, got.decided, got.last, got.msg_end);
			else begin
				$write("%0t: expected user %0d bit %0b last %0b end %0b,",
					$realtime, want.usr, want.decided, want.last, want.msg_end);
				$display(" got user %0d bit %0b last %0b end %0b",
					got.usr, got.decided, got.last, got.msg_end);
			end
		end
	endtask

	// Driver: input chips from the queue with random gaps, random output stalls.
	// A chip stays on the port until the block takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (!in_valid || in_ready) begin
				if (pending_chips.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					chip_value <= pending_chips.pop_front();
				end else
					in_valid <= 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: check each output transaction against the oldest expectation,
	// then fold in any input or register transaction taken at this edge.
	always @(posedge clk) begin
		decision_t got;
		decision_t want;

		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{user_index, bit_value, last_of_symbol, message_end};
				if (expected_bits.size() == 0)
					flag_mismatch('0, got, 1'b0);
				else begin
					want = expected_bits.pop_front();
					if (got.usr !== want.usr || got.decided !== want.decided ||
						got.last !== want.last || got.msg_end !== want.msg_end)
						flag_mismatch(want, got, 1'b1);
				end
			end
			if (in_valid && in_ready)
				despread_chip(chip_value);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_NUM_USERS)
					users_reg = cfg_data[NU_W-1:0];
				else
					msg_len_reg = cfg_data;
			end
		end
	end

	// Block has taken every chip and sent every decision; then let any
	// mid-symbol work settle before touching registers.
	task automatic wait_idle();
		while (pending_chips.size() != 0 || in_valid || expected_bits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [ML_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// One symbol's worth of chips as sent by the active users with random bits.
	task automatic push_symbol(int users);
		int          code_len;
		int          level;
		logic [15:0] tx_bits;
		logic [3:0]  u4;
		logic [3:0]  k4;

		code_len = (users > SHORT_CODE_LEN) ? LONG_CODE_LEN : SHORT_CODE_LEN;
		tx_bits = 16'($urandom);
		for (int k = 0; k < code_len; k++) begin
			level = 0;
			k4 = k[3:0];
			for (int u = 0; u < users; u++) begin
				u4 = u[3:0];
				level += (tx_bits[u] ^ (^(u4 & k4))) ? 1 : -1;
			end
			pending_chips.push_back(CHIP_W'(level));
		end
	endtask

	// Stray chips over the full 6-bit range; these also knock symbols off
	// alignment.
	task automatic push_noise(int n);
		for (int i = 0; i < n; i++)
			pending_chips.push_back(CHIP_W'($urandom_range(63)));
	endtask

	initial begin
		int queued;
		int users;
		int stray;

		for (int u = 0; u < MAX_USERS; u++)
			corr[u] = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed: reset settings, a symbol of extreme chip values.
		pending_chips.push_back(6'sd31);
		pending_chips.push_back(-6'sd32);
		pending_chips.push_back(6'sd0);
		pending_chips.push_back(6'sd16);
		pending_chips.push_back(-6'sd16);
		pending_chips.push_back(6'sd1);
		pending_chips.push_back(-6'sd1);
		pending_chips.push_back(6'sd31);
		wait_idle();

		// Long code, stop ten chips in, then drop to zero users (one user,
		// short code): the next chip closes the symbol.
		write_reg(REG_NUM_USERS, 13'd16);
		push_noise(10);
		wait_idle();
		write_reg(REG_NUM_USERS, 13'd0);
		pending_chips.push_back(-6'sd32);
		wait_idle();

		// Message already two symbols in; shrinking it to two ends it on the
		// next symbol.
		write_reg(REG_MESSAGE_LENGTH, 13'd2);
		push_symbol(1);
		wait_idle();

		// Random phases: mostly clean symbols, some stray chips.
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < 3) begin
				send_idle_pct = 25;
				recv_stall_pct = 83;
			end else if (p < 6) begin
				send_idle_pct = 83;
				recv_stall_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			// Upper data bits are junk for the user count register.
			write_reg(REG_NUM_USERS, {8'($urandom), 5'(PH_USERS[p])});
			write_reg(REG_MESSAGE_LENGTH, 13'(PH_MSG_LEN[p]));
			users = eff_users(PH_USERS[p] % 32);
			queued = 0;
			while (queued < CHIPS_PER_PHASE) begin
				if ($urandom_range(9) < 8) begin
					push_symbol(users);
					queued += (users > SHORT_CODE_LEN) ? LONG_CODE_LEN : SHORT_CODE_LEN;
				end else begin
					stray = 1 + int'($urandom_range(4));
					push_noise(stray);
					queued += stray;
				end
			end
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("tb_walsh_hadamard_despreader passed");
		else
			$display("tb_walsh_hadamard_despreader failed");
		$finish;
	end

	// Hang guard, well past the slowest legal run.
	initial begin
		#2000000;
		$display("tb_walsh_hadamard_despreader failed");
		$finish;
	end

endmodule
